FILE: rtl/assert_macros.svh
// Assertion macros shared by the sparse associative memory RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside of reset.
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_PROP(label, !(cond), msg)

`endif

FILE: rtl/sam_pkg.sv
// Package with constants and control types of the sparse associative memory.
package sam_pkg;

	localparam int unsigned DEF_ENTRIES = 256;
	localparam int unsigned DATA_W = 32;

	typedef struct packed {
		logic start;
		logic scan;
		logic resolve;
		logic commit;
	} sam_cmd_t;

	typedef struct packed {
		logic match;
		logic exhausted;
		logic out_free;
	} sam_sts_t;

endpackage

FILE: rtl/sam_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module sam_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/sam_dp.sv
// Datapath of the sparse associative memory: stores, scan counter, fill count, result word.
`include "assert_macros.svh"

module sam_dp #(
	parameter int unsigned ENTRIES = sam_pkg::DEF_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sam_pkg::sam_cmd_t              cmd,
	output sam_pkg::sam_sts_t              sts,
	input  logic                           func,
	input  logic [sam_pkg::DATA_W-1:0]     address,
	input  logic signed [sam_pkg::DATA_W-1:0] write_value,
	output logic signed [sam_pkg::DATA_W-1:0] read_value,
	output logic                           hit,
	output logic                           dropped,
	output logic                           out_valid,
	input  logic                           out_stall
);
	import sam_pkg::*;

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned FW = $clog2(ENTRIES + 1);

	logic              func_q;
	logic [DATA_W-1:0] addr_q;
	logic [DATA_W-1:0] wval_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     issue_q;
	logic              pend_s1;
	logic [IW-1:0]     idx_s1;
	logic              hit_q;
	logic [IW-1:0]     match_idx_q;
	logic [DATA_W-1:0] value_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] rval_q;
	logic              hit_out_q;
	logic              drop_q;

	logic              rd_en;
	logic [DATA_W-1:0] key_rdata;
	logic [DATA_W-1:0] val_rdata;
	logic              full;
	logic              alloc;
	logic              key_we;
	logic              val_we;
	logic [IW-1:0]     wr_idx;

	assign rd_en = cmd.scan && (issue_q < fill_q);
	assign full = (fill_q == FW'(ENTRIES));
	assign alloc = cmd.commit && func_q && !hit_q && !full;
	assign key_we = alloc;
	assign val_we = cmd.commit && func_q && (hit_q || !full);
	assign wr_idx = hit_q ? match_idx_q : fill_q[IW-1:0];

	assign sts.match = pend_s1 && (key_rdata == addr_q);
	assign sts.exhausted = !pend_s1 && (issue_q >= fill_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	sam_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (wr_idx),
		.wdata (addr_q),
		.re    (rd_en),
		.raddr (issue_q[IW-1:0]),
		.rdata (key_rdata)
	);

	sam_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (wr_idx),
		.wdata (wval_q),
		.re    (rd_en),
		.raddr (issue_q[IW-1:0]),
		.rdata (val_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			issue_q <= '0;
			pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				issue_q <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.scan) begin
				pend_s1 <= rd_en;
				if (rd_en) begin
					issue_q <= issue_q + 1'b1;
				end
			end
			if (alloc) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q <= func;
			addr_q <= address;
			wval_q <= write_value;
		end
		if (cmd.scan && rd_en) begin
			idx_s1 <= issue_q[IW-1:0];
		end
		if (cmd.resolve) begin
			hit_q <= sts.match;
			match_idx_q <= idx_s1;
			value_q <= val_rdata;
		end
		if (cmd.commit) begin
			rval_q <= (!func_q && hit_q) ? value_q : '0;
			hit_out_q <= hit_q;
			drop_q <= func_q && !hit_q && full;
		end
	end

	assign out_valid = out_valid_q;
	assign read_value = rval_q;
	assign hit = hit_out_q;
	assign dropped = drop_q;

	`ASSERT_NEVER(a_fill_range, fill_q > FW'(ENTRIES), "fill count beyond table size")
	`ASSERT_PROP(a_fill_step, fill_q != $past(fill_q) |-> fill_q == $past(fill_q) + 1'b1, "fill count jumped")
	`ASSERT_PROP(a_commit_word, cmd.commit |=> out_valid_q, "committed word not presented")

endmodule

FILE: rtl/sam_ctrl.sv
// Controller state machine of the sparse associative memory.
`include "assert_macros.svh"

module sam_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output sam_pkg::sam_cmd_t cmd,
	input  sam_pkg::sam_sts_t sts
);
	import sam_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   found;

	assign found = sts.match || sts.exhausted;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.resolve = found;
				cmd.scan = !found;
			end
			ST_FINISH: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (found) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEVER(a_commit_blocked, cmd.commit && !sts.out_free, "commit over a waiting word")

endmodule

FILE: rtl/sparse_associative_memory.sv
// Top level of the sparse associative memory.
// A fully associative table of ENTRIES address/value pairs, filled in order and never
// emptied except by reset. Each word is a read or a write; a linear scan through the
// key memory, one stored entry per cycle over its single read port, looks for the
// address; the scan covers only the entries in use. The next word is accepted while a
// finished result still waits at the output.
`include "assert_macros.svh"

module sparse_associative_memory #(
	parameter int unsigned ENTRIES = sam_pkg::DEF_ENTRIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic [sam_pkg::DATA_W-1:0]        address,
	input  logic signed [sam_pkg::DATA_W-1:0] write_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [sam_pkg::DATA_W-1:0] read_value,
	output logic                              hit,
	output logic                              dropped
);
	import sam_pkg::*;

	sam_cmd_t cmd;
	sam_sts_t sts;

	sam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	sam_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.address     (address),
		.write_value (write_value),
		.read_value  (read_value),
		.hit         (hit),
		.dropped     (dropped),
		.out_valid   (out_valid),
		.out_stall   (out_stall)
	);

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the sparse associative memory with a predicting checker class.
module tb;

	import sam_pkg::*;

	localparam int unsigned ENTRIES = DEF_ENTRIES;
	localparam int unsigned RANDOM_WORDS = 1800;
	localparam int unsigned QUIET_LIMIT = 20 * (ENTRIES + 4);

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} access_op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic                     hit;
		logic                     dropped;
	} access_result_t;

	class lookup_checker;
		logic [DATA_W-1:0]        keys[$];
		logic signed [DATA_W-1:0] values[$];
		access_result_t           pending[$];
		int unsigned              capacity;
		int unsigned              fails;
		int unsigned              read_hits, read_misses, updates, allocations, drops;

		function new(int unsigned cap);
			capacity = cap;
		endfunction

		function void note_word(access_op_t op, logic [DATA_W-1:0] addr,
				logic signed [DATA_W-1:0] val);
			access_result_t r;
			int             idx;
			r = '0;
			idx = -1;
			foreach (keys[i])
				if (idx < 0 && keys[i] == addr)
					idx = i;
			if (op == OP_READ) begin
				if (idx >= 0) begin
					r.read_value = values[idx];
					r.hit = 1'b1;
					read_hits++;
				end else
					read_misses++;
			end else if (idx >= 0) begin
				values[idx] = val;
				r.hit = 1'b1;
				updates++;
			end else if (keys.size() < capacity) begin
				keys.push_back(addr);
				values.push_back(val);
				allocations++;
			end else begin
				r.dropped = 1'b1;
				drops++;
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [DATA_W-1:0] rv, logic h, logic d);
			access_result_t e;
			if (pending.size() == 0) begin
				$error("Result word with nothing pending: read_value %0d, hit %0b, dropped %0b",
					rv, h, d);
				fails++;
				return;
			end
			e = pending.pop_front();
			if (rv !== e.read_value) begin
				$error("read_value: expected %0d, actual %0d", e.read_value, rv);
				fails++;
			end
			if (h !== e.hit) begin
				$error("hit: expected %0b, actual %0b", e.hit, h);
				fails++;
			end
			if (d !== e.dropped) begin
				$error("dropped: expected %0b, actual %0b", e.dropped, d);
				fails++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     func = 1'b0;
	logic [DATA_W-1:0]        address = '0;
	logic signed [DATA_W-1:0] write_value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] read_value;
	logic                     hit;
	logic                     dropped;

	bit            idle_enabled = 1'b1;
	lookup_checker lookup = new(ENTRIES);

	sparse_associative_memory #(
		.ENTRIES(ENTRIES)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.address    (address),
		.write_value(write_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.hit        (hit),
		.dropped    (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= idle_enabled && ($urandom_range(0, 99) < 27);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			lookup.check_result(read_value, hit, dropped);
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	task automatic send_word(access_op_t op, logic [DATA_W-1:0] addr,
			logic signed [DATA_W-1:0] val);
		while (idle_enabled && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		address <= addr;
		write_value <= val;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		lookup.note_word(op, addr, val);
		@(negedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] data_word();
		case ($urandom_range(0, 9))
			0: data_word = 32'sh8000_0000;
			1: data_word = 32'sh7FFF_FFFF;
			2: data_word = '0;
			3: data_word = -1;
			default: data_word = $urandom;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] fresh_key();
		int unsigned nk;
		nk = lookup.keys.size();
		if (nk > 0 && $urandom_range(0, 1) == 0)
			fresh_key = lookup.keys[$urandom_range(0, nk - 1)] ^ (32'd1 << $urandom_range(0, 31));
		else
			fresh_key = $urandom;
	endfunction

	initial begin : stimulus
		int unsigned      n;
		int unsigned      r;
		int unsigned      nk;
		logic [DATA_W-1:0] a;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table, extreme keys and values, updates, and near misses.
		send_word(OP_READ, 32'h0000_0000, 32'sh1234_5678);
		send_word(OP_READ, 32'hFFFF_FFFF, '0);
		send_word(OP_WRITE, 32'h0000_0000, 32'sh7FFF_FFFF);
		send_word(OP_WRITE, 32'hFFFF_FFFF, 32'sh8000_0000);
		send_word(OP_READ, 32'h0000_0000, -1);
		send_word(OP_READ, 32'hFFFF_FFFF, '0);
		send_word(OP_WRITE, 32'h0000_0000, '0);
		send_word(OP_READ, 32'h0000_0000, '0);
		send_word(OP_READ, 32'h0000_0001, '0);
		send_word(OP_READ, 32'h8000_0000, '0);
		send_word(OP_WRITE, 32'h8000_0000, -1);
		send_word(OP_WRITE, 32'h7FFF_FFFF, 32'sh0000_0001);
		send_word(OP_READ, 32'h8000_0000, '0);
		send_word(OP_READ, 32'h7FFF_FFFF, 32'sh7FFF_FFFF);
		send_word(OP_WRITE, 32'hFFFF_FFFF, 32'sh1234_5678);
		send_word(OP_READ, 32'hFFFF_FFFF, '0);
		send_word(OP_READ, 32'hFFFF_FFFE, '0);

		for (n = 0; n < RANDOM_WORDS; n++) begin
			idle_enabled = !(n >= 700 && n < 1000);
			nk = lookup.keys.size();
			r = $urandom_range(0, 99);
			a = (nk > 0) ? lookup.keys[$urandom_range(0, nk - 1)] : fresh_key();
			if (r < 35)
				send_word(OP_READ, a, data_word());
			else if (r < 45)
				send_word(OP_READ, fresh_key(), data_word());
			else if (r < 70)
				send_word(OP_WRITE, a, data_word());
			else if (r < 95)
				send_word(OP_WRITE, fresh_key(), data_word());
			else
				send_word(access_op_t'($urandom_range(0, 1)),
					($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000, data_word());
		end
		in_valid <= 1'b0;
		idle_enabled = 1'b1;

		while (lookup.pending.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
		@(negedge clk);

		$display("Checked %0d read hits, %0d read misses, %0d updates, %0d allocations, %0d dropped writes.",
			lookup.read_hits, lookup.read_misses, lookup.updates, lookup.allocations, lookup.drops);
		$display("The table ended with %0d of %0d entries in use.", lookup.keys.size(), ENTRIES);
		if (lookup.fails == 0 && lookup.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
